@@ sv/atrp_pkg.sv @@
// Package for the accelerometer tilt unit: widths, constants, CORDIC angle table.
// Used by every module of the unit; depends on nothing.
package atrp_pkg;

    localparam int ANGLE_FRAC_BITS = 7;
    localparam int ACC_FRAC        = 24;
    localparam int CORDIC_STEPS    = 28;
    localparam int SQ_STEPS        = 32;   // result bits of the square root
    localparam int AW              = 64;   // radicand and partial root width
    localparam int VW              = 50;   // CORDIC datapath width
    localparam int ACCW            = 34;   // angle accumulator width

    localparam logic signed [15:0] OFFSET_X_RST = 16'sd230;
    localparam logic signed [15:0] OFFSET_Y_RST = 16'sd50;
    localparam logic signed [15:0] OFFSET_Z_RST = -16'sd10;

    localparam logic [1:0] REG_OFFSET_X = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y = 2'd1;
    localparam logic [1:0] REG_OFFSET_Z = 2'd2;

    localparam logic signed [ACCW-1:0] DEG90 = ACCW'(64'sd90 <<< ACC_FRAC);
    localparam logic signed [ACCW-1:0] DEG180 = ACCW'(64'sd180 <<< ACC_FRAC);

    // Square root cell state. The partial root starts at the trial bit and
    // only narrows to 32 bits by the last step, so it is kept full width.
    typedef struct packed {
        logic [AW-1:0] rem;
        logic [AW-1:0] res;
    } t_sq;

    // CORDIC cell state.
    typedef struct packed {
        logic signed [VW-1:0]   px;
        logic signed [VW-1:0]   py;
        logic signed [ACCW-1:0] acc;
    } t_cv;

    // Side information carried along with each item.
    typedef struct packed {
        logic undef;
        logic z_neg;
        logic y_neg;
    } t_side;

    function automatic logic signed [ACCW-1:0] atan_tab(input int i);
        logic signed [ACCW-1:0] t;
        case (i)
            0: t = 754974720;  1: t = 445687602;  2: t = 235489088;  3: t = 119537938;
            4: t = 60000934;   5: t = 30029717;   6: t = 15018523;   7: t = 7509720;
            8: t = 3754917;    9: t = 1877466;    10: t = 938734;    11: t = 469367;
            12: t = 234684;    13: t = 117342;    14: t = 58671;     15: t = 29335;
            16: t = 14668;     17: t = 7334;      18: t = 3667;      19: t = 1833;
            20: t = 917;       21: t = 458;       22: t = 229;       23: t = 115;
            24: t = 57;        25: t = 29;        26: t = 14;        27: t = 7;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

@@ sv/atrp_sqrt_cell.sv @@
// One step of the digit-by-digit integer square root, registered.
// Depends on atrp_pkg.
module atrp_sqrt_cell import atrp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_en,
    input  logic [4:0] i_step,
    input  t_sq      i_d,
    output t_sq      o_d
);
    logic [AW-1:0] bit_v;
    logic [AW-1:0] trial;
    t_sq           n_d;
    t_sq           r_d;

    // Bit to try at this step: 2^(62 - 2*step). Leading zero bits of the
    // radicand are harmless: trial fails and res stays zero.
    always_comb begin
        bit_v = AW'(64'd1) << (6'd62 - {i_step, 1'b0});
        trial = i_d.rem - (i_d.res + bit_v);
        if (i_d.rem >= i_d.res + bit_v) begin
            n_d.rem = trial;
            n_d.res = (i_d.res >> 1) + bit_v;
        end else begin
            n_d.rem = i_d.rem;
            n_d.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_d <= n_d;
    end
    assign o_d = r_d;
endmodule

@@ sv/atrp_cordic_cell.sv @@
// One vectoring CORDIC rotation, registered.
// Depends on atrp_pkg.
module atrp_cordic_cell import atrp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_en,
    input  logic [4:0] i_step,
    input  t_cv      i_d,
    output t_cv      o_d
);
    logic signed [VW-1:0]   dx, dy;
    logic signed [ACCW-1:0] ang;
    t_cv                    n_d;
    t_cv                    r_d;

    always_comb begin
        dx  = i_d.py >>> i_step;
        dy  = i_d.px >>> i_step;
        ang = atan_tab(int'(i_step));
        if (!i_d.py[VW-1]) begin
            n_d.px  = i_d.px + dx;
            n_d.py  = i_d.py - dy;
            n_d.acc = i_d.acc + ang;
        end else begin
            n_d.px  = i_d.px - dx;
            n_d.py  = i_d.py + dy;
            n_d.acc = i_d.acc - ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_d <= n_d;
    end
    assign o_d = r_d;
endmodule

@@ sv/accel_tilt_roll_pitch_unit.sv @@
// Top level of the accelerometer tilt unit: offset correction, normalising,
// two square-root cell chains, two CORDIC cell chains, rounding. Uses atrp_pkg.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-------------------------------------
//  s_axis   | in  | tvalid / tready     | tdata: raw_x, raw_y, raw_z (48 bits)
//  m_axis   | out | tvalid / tready     | tdata: roll, pitch (32 bits); tuser: flag
//  apb      | in  | psel/penable/pwrite | offset_x, offset_y, offset_z
//
// One sample is taken every cycle unless the row stalls. Stages in order:
// one for offset correction and normalising shift, one for the squares, 32
// square root cells, 28 CORDIC cells, one for folding, rounding and output.
// The whole row of cells advances together; when the output register is
// full and not taken, the row stalls and s_axis_tready falls.
// Reset clears the valid bits of the row and restores the offset registers.
module accel_tilt_roll_pitch_unit import atrp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // raw_x[15:0], raw_y[31:16], raw_z[47:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // roll[15:0], pitch[30:16], bit 31 zero
    output logic        m_axis_tuser,   // undefined_flag[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int NS = 2 + SQ_STEPS + CORDIC_STEPS + 1;

    logic signed [15:0] r_off_x, r_off_y, r_off_z;
    logic [1:0] reg_idx;
    logic       en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= OFFSET_X_RST;
            r_off_y <= OFFSET_Y_RST;
            r_off_z <= OFFSET_Z_RST;
        end else if (psel && penable && pwrite && (paddr[1:0] == 2'b00)) begin
            unique case (reg_idx)
                REG_OFFSET_X: r_off_x <= pwdata[15:0];
                REG_OFFSET_Y: r_off_y <= pwdata[15:0];
                REG_OFFSET_Z: r_off_z <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_OFFSET_X: prdata = {{16{r_off_x[15]}}, r_off_x};
            REG_OFFSET_Y: prdata = {{16{r_off_y[15]}}, r_off_y};
            REG_OFFSET_Z: prdata = {{16{r_off_z[15]}}, r_off_z};
            default:      prdata = '0;
        endcase
    end

    // Valid bits of the row; the row moves as one whenever the output may take.
    logic [NS-1:0] r_vld;
    assign en            = !m_axis_tvalid || m_axis_tready || !r_vld[NS-1];
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en)  r_vld <= {r_vld[NS-2:0], s_axis_tvalid};
    end

    // Stage 0: correction and common normalising shift.
    logic signed [15:0] cx, cy, cz;
    logic [15:0] mx, my, mz, mm;
    logic [3:0]  sh;
    logic signed [16:0] ax, ay, az;
    logic signed [16:0] r_a, r_b, r_c;
    t_side       n_side, r_side0;

    always_comb begin
        cx = s_axis_tdata[15:0]  - r_off_x;
        cy = s_axis_tdata[31:16] - r_off_y;
        cz = s_axis_tdata[47:32] - r_off_z;
        mx = cx[15] ? 16'(-cx) : cx;
        my = cy[15] ? 16'(-cy) : cy;
        mz = cz[15] ? 16'(-cz) : cz;
        mm = mx | my | mz;
        sh = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (mm[i]) sh = 4'(15 - i);
        end
        ax = 17'(cx) <<< sh;
        ay = 17'(cy) <<< sh;
        az = 17'(cz) <<< sh;
        n_side.undef = (mm == 16'd0);
        n_side.z_neg = cz[15];
        n_side.y_neg = cy[15];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= ax; r_b <= ay; r_c <= az; r_side0 <= n_side;
        end
    end

    // Stage 1: squares and radicands.
    logic [33:0] sa, sb, sc;
    t_sq  r_sqr0, r_sqp0;
    logic signed [16:0] r_a1, r_b1;
    t_side r_side1;
    always_comb begin
        sa = 34'(r_a * r_a);
        sb = 34'(r_b * r_b);
        sc = 34'(r_c * r_c);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqr0.rem <= AW'({30'd0, sa} + {30'd0, sc}) << 30;
            r_sqr0.res <= '0;
            r_sqp0.rem <= AW'({30'd0, sb} + {30'd0, sc}) << 30;
            r_sqp0.res <= '0;
            r_a1 <= r_a; r_b1 <= r_b; r_side1 <= r_side0;
        end
    end

    // Square root rows; the numerators and side bits ride alongside.
    t_sq sq_r [SQ_STEPS+1];
    t_sq sq_p [SQ_STEPS+1];
    logic signed [16:0] r_da [SQ_STEPS+1];
    logic signed [16:0] r_db [SQ_STEPS+1];
    t_side r_ds [SQ_STEPS+1];
    assign sq_r[0] = r_sqr0;
    assign sq_p[0] = r_sqp0;
    assign r_da[0] = r_a1;
    assign r_db[0] = r_b1;
    assign r_ds[0] = r_side1;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
        atrp_sqrt_cell u_r (.i_clk(i_clk), .i_en(en), .i_step(5'(g)),
                            .i_d(sq_r[g]), .o_d(sq_r[g+1]));
        atrp_sqrt_cell u_p (.i_clk(i_clk), .i_en(en), .i_step(5'(g)),
                            .i_d(sq_p[g]), .o_d(sq_p[g+1]));
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_da[g+1] <= r_da[g]; r_db[g+1] <= r_db[g]; r_ds[g+1] <= r_ds[g];
            end
        end
    end

    // CORDIC rows.
    t_cv cv_r [CORDIC_STEPS+1];
    t_cv cv_p [CORDIC_STEPS+1];
    t_side r_cs [CORDIC_STEPS+1];
    always_comb begin
        cv_r[0].px  = VW'({1'b0, sq_r[SQ_STEPS].res});
        cv_r[0].py  = VW'(r_db[SQ_STEPS]) <<< 15;
        cv_r[0].acc = '0;
        cv_p[0].px  = VW'({1'b0, sq_p[SQ_STEPS].res});
        cv_p[0].py  = VW'(r_da[SQ_STEPS]) <<< 15;
        cv_p[0].acc = '0;
    end
    assign r_cs[0] = r_ds[SQ_STEPS];

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cv
        atrp_cordic_cell u_r (.i_clk(i_clk), .i_en(en), .i_step(5'(g)),
                              .i_d(cv_r[g]), .o_d(cv_r[g+1]));
        atrp_cordic_cell u_p (.i_clk(i_clk), .i_en(en), .i_step(5'(g)),
                              .i_d(cv_p[g]), .o_d(cv_p[g+1]));
        always_ff @(posedge i_clk) begin
            if (en) r_cs[g+1] <= r_cs[g];
        end
    end

    // Final stage: clamp, negate pitch, fold roll, clamp again, round, saturate, zero if undefined.
    localparam int SHR = ACC_FRAC - ANGLE_FRAC_BITS;
    logic signed [ACCW-1:0] rl, pt, rr_, rp_;
    logic signed [ACCW-1:0] qr, qp;
    logic [15:0] roll_f;
    logic [14:0] pitch_f;
    t_side fs;
    logic [31:0] r_out;
    logic        r_flag;

    always_comb begin
        fs = r_cs[CORDIC_STEPS];
        rl = cv_r[CORDIC_STEPS].acc;
        pt = cv_p[CORDIC_STEPS].acc;
        if (rl > DEG90) rl = DEG90;
        if (rl < -DEG90) rl = -DEG90;
        if (pt > DEG90) pt = DEG90;
        if (pt < -DEG90) pt = -DEG90;
        pt = -pt;
        if (fs.z_neg) rl = (fs.y_neg ? -DEG180 : DEG180) - rl;
        // A small negative residue folded with y at zero can pass 180 degrees.
        if (rl > DEG180) rl = DEG180;
        if (rl < -DEG180) rl = -DEG180;
        rr_ = rl + (ACCW'(1) <<< (SHR - 1));
        rp_ = pt + (ACCW'(1) <<< (SHR - 1));
        qr = rr_ >>> SHR;
        qp = rp_ >>> SHR;
        if (qr > 32767)       roll_f = 16'h7FFF;
        else if (qr < -32768) roll_f = 16'h8000;
        else                  roll_f = qr[15:0];
        if (qp > 16383)       pitch_f = 15'h3FFF;
        else if (qp < -16384) pitch_f = 15'h4000;
        else                  pitch_f = qp[14:0];
        if (fs.undef) begin
            roll_f  = '0;
            pitch_f = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out  <= {1'b0, pitch_f, roll_f};
            r_flag <= fs.undef;
        end
    end
    assign m_axis_tdata = r_out;
    assign m_axis_tuser = r_flag;
endmodule
